FILE: design/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// shared constants, codes, command and status types and the container wrap
// for the rpn integer evaluator
// ----------------------------------------------------------------------------
package rie_pkg;

	localparam int StackDepth = 32;
	localparam int NumVars    = 16;
	localparam int ValW       = 64;
	localparam int BitsW      = 7;
	localparam int IdxW       = 8;
	localparam int SpW        = $clog2(StackDepth);
	localparam int DepthW     = $clog2(StackDepth + 1);
	localparam int VarW       = (NumVars > 1) ? $clog2(NumVars) : 1;
	localparam int CntW       = $clog2(ValW + 1);
	localparam int TagW       = IdxW + 1;

	localparam logic [1:0] KIND_CONST = 2'd0;
	localparam logic [1:0] KIND_VAR   = 2'd1;
	localparam logic [1:0] KIND_OP    = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_SUB    = 3'd1;
	localparam logic [2:0] OP_MUL    = 3'd2;
	localparam logic [2:0] OP_DIV    = 3'd3;
	localparam logic [2:0] OP_ASSIGN = 3'd4;
	localparam logic [2:0] OP_RETURN = 3'd5;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_RET = 2'd1;
	localparam logic [1:0] ST_ERR = 2'd2;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_STACK_FULL = 4'd1;
	localparam logic [3:0] ERR_FEW_OPNDS  = 4'd2;
	localparam logic [3:0] ERR_BAD_INDEX  = 4'd3;
	localparam logic [3:0] ERR_UNASSIGNED = 4'd4;
	localparam logic [3:0] ERR_REASSIGNED = 4'd5;
	localparam logic [3:0] ERR_NOT_VAR    = 4'd6;
	localparam logic [3:0] ERR_DIV_ZERO   = 4'd7;
	localparam logic [3:0] ERR_NO_RETURN  = 4'd8;
	localparam logic [3:0] ERR_UNKNOWN_OP = 4'd9;

	typedef struct packed {
		logic       load_tok;
		logic       push;
		logic       sread;
		logic       sread_top;
		logic       vread;
		logic       load_opnd;
		logic       opnd_src_var;
		logic       opnd_right;
		logic       var_write;
		logic       unit_start;
		logic       stack_wb;
		logic       emit;
		logic       clear;
		logic [1:0] emit_status;
		logic [3:0] emit_err;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] op;
		logic       full;
		logic       depth_zero;
		logic       depth_lt2;
		logic       tag_var;
		logic       idx_bad;
		logic       var_set;
		logic       rv_zero;
		logic       unit_done;
		logic       out_busy;
	} stat_t;

	function automatic logic [ValW-1:0] wrap_container(input logic [ValW-1:0] v,
		input logic [BitsW-1:0] bits);
		logic [ValW-1:0] r;
		if (bits <= BitsW'(8)) begin
			r = {{(ValW-8){v[7]}}, v[7:0]};
		end else if (bits <= BitsW'(16)) begin
			r = {{(ValW-16){v[15]}}, v[15:0]};
		end else if (bits <= BitsW'(32)) begin
			r = {{(ValW-32){v[31]}}, v[31:0]};
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: design/rpn_integer_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_integer_evaluator
// evaluates a stream of rpn tokens against an operand stack and a
// write-once variable file, one result per token
//
// input channel: in_valid / in_stall carry one token request (kind,
// operation, constant value and width, variable index)
// output channel: out_valid / out_stall carry one result request per token
// (status, error code, returned value and its width)
// one token is worked at a time; push and errors found at decode go straight
// to emit, return reads the top, assign reads both operands and writes the
// variable, add and sub read both and write back, mul and div also run the
// one-bit-per-cycle shift-add / restoring divide unit before the write-back;
// each variable operand adds a variable read and an error ends the token at
// the step that finds it; the result is valid in the same cycle as the next
// token can be accepted and sits in an output register, so the next token
// is taken while a stalled result waits; a new result waits for it to drain
// reset empties the stack and marks all variables unassigned at once
// ----------------------------------------------------------------------------
module rpn_integer_evaluator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                token_kind,
	input  logic [2:0]                operation,
	input  logic signed [63:0]        const_value,
	input  logic [6:0]                const_bits,
	input  logic [7:0]                var_index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [3:0]                error_code,
	output logic signed [63:0]        result_value,
	output logic [6:0]                result_bits
);

	rie_pkg::cmd_t  cmd;
	rie_pkg::stat_t stat;

	rie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rie_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.token_kind   (token_kind),
		.operation    (operation),
		.const_value  (const_value),
		.const_bits   (const_bits),
		.var_index    (var_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.error_code   (error_code),
		.result_value (result_value),
		.result_bits  (result_bits)
	);

endmodule

FILE: design/rie_muldiv.sv
// ----------------------------------------------------------------------------
// rie_muldiv
// shared iterative unit: shift-add multiply and restoring divide on operand
// magnitudes, one bit per cycle, with signed product overflow flag
// ----------------------------------------------------------------------------
module rie_muldiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       is_div,
	input  logic [rie_pkg::ValW-1:0]   a,
	input  logic [rie_pkg::ValW-1:0]   b,
	output logic                       done,
	output logic [rie_pkg::ValW-1:0]   result,
	output logic                       ovf
);

	localparam int W = rie_pkg::ValW;

	logic                      run_q;
	logic [rie_pkg::CntW-1:0]  cnt_q;
	logic                      div_q;
	logic                      neg_q;
	logic [W-1:0]              m_q;
	logic [W-1:0]              hi_q;
	logic [W-1:0]              lo_q;
	logic [W-1:0]              ma;
	logic [W-1:0]              mb;
	logic [W:0]                sum;
	logic [W:0]                trial;
	logic [W:0]                diff;
	logic                      ge;
	logic                      step;

	assign ma    = a[W-1] ? ('0 - a) : a;
	assign mb    = b[W-1] ? ('0 - b) : b;
	assign sum   = {1'b0, hi_q} + {1'b0, (lo_q[0] ? m_q : '0)};
	assign trial = {hi_q, lo_q[W-1]};
	assign diff  = trial - {1'b0, m_q};
	assign ge    = ~diff[W];
	assign step  = run_q && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= rie_pkg::CntW'(W);
		end else if (step) begin
			cnt_q <= cnt_q - rie_pkg::CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[W-1] ^ b[W-1];
			m_q   <= is_div ? mb : ma;
			lo_q  <= is_div ? ma : mb;
			hi_q  <= '0;
		end else if (step) begin
			if (div_q) begin
				hi_q <= ge ? diff[W-1:0] : trial[W-1:0];
				lo_q <= {lo_q[W-2:0], ge};
			end else begin
				hi_q <= sum[W:1];
				lo_q <= {sum[0], lo_q[W-1:1]};
			end
		end
	end

	assign done   = run_q && (cnt_q == '0);
	assign result = neg_q ? ('0 - lo_q) : lo_q;
	assign ovf    = ~div_q && ((hi_q != '0) ||
		(lo_q[W-1] && (~neg_q || (lo_q[W-2:0] != '0))));

endmodule

FILE: design/rie_dpath.sv
// ----------------------------------------------------------------------------
// rie_dpath
// datapath: token register, operand stack memory, variable file, operand
// registers, arithmetic, iterative unit and the output register
// ----------------------------------------------------------------------------
module rie_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rie_pkg::cmd_t               cmd,
	output rie_pkg::stat_t              stat,
	input  logic [1:0]                  token_kind,
	input  logic [2:0]                  operation,
	input  logic [rie_pkg::ValW-1:0]    const_value,
	input  logic [rie_pkg::BitsW-1:0]   const_bits,
	input  logic [rie_pkg::IdxW-1:0]    var_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [3:0]                  error_code,
	output logic [rie_pkg::ValW-1:0]    result_value,
	output logic [rie_pkg::BitsW-1:0]   result_bits
);

	localparam int W  = rie_pkg::ValW;
	localparam int BW = rie_pkg::BitsW;
	localparam int DW = rie_pkg::DepthW;

	logic [1:0]                 kind_q;
	logic [2:0]                 op_q;
	logic [W-1:0]               cval_q;
	logic [BW-1:0]              cbits_q;
	logic [rie_pkg::IdxW-1:0]   vidx_q;

	logic [DW-1:0]              depth_q;
	logic [W-1:0]               stk_val_mem [rie_pkg::StackDepth];
	logic [rie_pkg::TagW-1:0]   stk_tag_mem [rie_pkg::StackDepth];
	logic [W-1:0]               srd_val_q;
	logic [rie_pkg::TagW-1:0]   srd_tag_q;

	logic [W-1:0]               var_val_mem [rie_pkg::NumVars];
	logic [BW-1:0]              var_bits_mem [rie_pkg::NumVars];
	logic [rie_pkg::NumVars-1:0] var_set_q;
	logic [W-1:0]               vrd_val_q;
	logic [BW-1:0]              vrd_bits_q;

	logic [W-1:0]               lv_q;
	logic [BW-1:0]              lb_q;
	logic [W-1:0]               rv_q;
	logic [BW-1:0]              rb_q;

	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [3:0]                 err_q;
	logic [W-1:0]               val_q;
	logic [BW-1:0]              bits_q;

	logic [DW-1:0]              depth_m1;
	logic [DW-1:0]              depth_m2;
	logic [BW-1:0]              push_bits;
	logic [W-1:0]               push_val;
	logic [rie_pkg::TagW-1:0]   push_tag;
	logic [rie_pkg::VarW-1:0]   tag_vidx;
	logic [W-1:0]               add_res;
	logic [W-1:0]               sub_res;
	logic                       add_ovf;
	logic                       sub_ovf;
	logic [W-1:0]               unit_res;
	logic                       unit_ovf;
	logic                       unit_done;
	logic [W-1:0]               op_res;
	logic                       op_ovf;
	logic [BW-1:0]              wmax;
	logic [BW-1:0]              wres;
	logic                       stk_we;
	logic [rie_pkg::SpW-1:0]    stk_waddr;
	logic [W-1:0]               stk_wval;
	logic [rie_pkg::TagW-1:0]   stk_wtag;

	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign tag_vidx = srd_tag_q[rie_pkg::VarW-1:0];

	// constant width clamp
	always_comb begin
		if (cbits_q == '0) begin
			push_bits = BW'(1);
		end else if (cbits_q > BW'(W)) begin
			push_bits = BW'(W);
		end else begin
			push_bits = cbits_q;
		end
	end

	assign push_val = (kind_q == rie_pkg::KIND_CONST) ?
		rie_pkg::wrap_container(cval_q, push_bits) : '0;
	assign push_tag = (kind_q == rie_pkg::KIND_CONST) ?
		{1'b0, 1'b0, push_bits} : {1'b1, vidx_q};

	assign add_res = lv_q + rv_q;
	assign sub_res = lv_q - rv_q;
	assign add_ovf = ((lv_q[W-1] ^ add_res[W-1]) & (rv_q[W-1] ^ add_res[W-1]));
	assign sub_ovf = ((lv_q[W-1] ^ rv_q[W-1]) & (lv_q[W-1] ^ sub_res[W-1]));
	assign wmax    = (lb_q > rb_q) ? lb_q : rb_q;

	always_comb begin
		case (op_q)
			rie_pkg::OP_ADD: begin
				op_res = add_res;
				op_ovf = add_ovf;
			end
			rie_pkg::OP_SUB: begin
				op_res = sub_res;
				op_ovf = sub_ovf;
			end
			default: begin
				op_res = unit_res;
				op_ovf = unit_ovf;
			end
		endcase
	end

	assign wres = op_ovf ? ((wmax > BW'(W / 2)) ? BW'(W) : {wmax[BW-2:0], 1'b0}) : wmax;

	rie_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.unit_start),
		.is_div (op_q == rie_pkg::OP_DIV),
		.a      (lv_q),
		.b      (rv_q),
		.done   (unit_done),
		.result (unit_res),
		.ovf    (unit_ovf)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			kind_q  <= token_kind;
			op_q    <= operation;
			cval_q  <= const_value;
			cbits_q <= const_bits;
			vidx_q  <= var_index;
		end
	end

	// stack write port
	always_comb begin
		stk_we    = cmd.push | cmd.stack_wb;
		stk_waddr = cmd.push ? depth_q[rie_pkg::SpW-1:0] : depth_m2[rie_pkg::SpW-1:0];
		stk_wval  = cmd.push ? push_val : rie_pkg::wrap_container(op_res, wres);
		stk_wtag  = cmd.push ? push_tag : {1'b0, 1'b0, wres};
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_val_mem[stk_waddr] <= stk_wval;
			stk_tag_mem[stk_waddr] <= stk_wtag;
		end
		if (cmd.sread) begin
			srd_val_q <= stk_val_mem[cmd.sread_top ? depth_m1[rie_pkg::SpW-1:0] :
				depth_m2[rie_pkg::SpW-1:0]];
			srd_tag_q <= stk_tag_mem[cmd.sread_top ? depth_m1[rie_pkg::SpW-1:0] :
				depth_m2[rie_pkg::SpW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.var_write) begin
			var_val_mem[tag_vidx]  <= lv_q;
			var_bits_mem[tag_vidx] <= lb_q;
		end
		if (cmd.vread) begin
			vrd_val_q  <= var_val_mem[tag_vidx];
			vrd_bits_q <= var_bits_mem[tag_vidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			var_set_q <= '0;
		end else if (cmd.clear) begin
			depth_q   <= '0;
			var_set_q <= '0;
		end else if (cmd.push) begin
			depth_q <= depth_q + DW'(1);
		end else if (cmd.var_write) begin
			depth_q             <= depth_m2;
			var_set_q[tag_vidx] <= 1'b1;
		end else if (cmd.stack_wb) begin
			depth_q <= depth_m1;
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (cmd.load_opnd) begin
			if (cmd.opnd_right) begin
				rv_q <= cmd.opnd_src_var ? vrd_val_q : srd_val_q;
				rb_q <= cmd.opnd_src_var ? vrd_bits_q : srd_tag_q[BW-1:0];
			end else begin
				lv_q <= cmd.opnd_src_var ? vrd_val_q : srd_val_q;
				lb_q <= cmd.opnd_src_var ? vrd_bits_q : srd_tag_q[BW-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			err_q    <= cmd.emit_err;
			val_q    <= (cmd.emit_status == rie_pkg::ST_RET) ? lv_q : '0;
			bits_q   <= (cmd.emit_status == rie_pkg::ST_RET) ? lb_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign error_code   = err_q;
	assign result_value = val_q;
	assign result_bits  = bits_q;

	always_comb begin
		stat.kind       = kind_q;
		stat.op         = op_q;
		stat.full       = (depth_q == DW'(rie_pkg::StackDepth));
		stat.depth_zero = (depth_q == '0);
		stat.depth_lt2  = (depth_q < DW'(2));
		stat.tag_var    = srd_tag_q[rie_pkg::TagW-1];
		stat.idx_bad    = ({1'b0, srd_tag_q[rie_pkg::IdxW-1:0]} >=
			(rie_pkg::IdxW + 1)'(rie_pkg::NumVars));
		stat.var_set    = var_set_q[tag_vidx];
		stat.rv_zero    = (rv_q == '0);
		stat.unit_done  = unit_done;
		stat.out_busy   = out_valid_q & out_stall;
	end

endmodule

FILE: design/rie_ctrl.sv
// ----------------------------------------------------------------------------
// rie_ctrl
// controller: sequences token decode, operand resolution, execution and
// result hand-off through commands to the datapath
// ----------------------------------------------------------------------------
module rie_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rie_pkg::stat_t  stat,
	output rie_pkg::cmd_t   cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_SCHK   = 8'b0000_0100,
		S_VCHK   = 8'b0000_1000,
		S_NEXT   = 8'b0001_0000,
		S_UNIT   = 8'b0010_0000,
		S_WB     = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] st_q;
	logic [1:0] st_d;
	logic [3:0] err_q;
	logic [3:0] err_d;
	logic       right_q;
	logic       right_d;
	logic       fail;
	logic [3:0] fcode;
	logic       ok;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		err_d   = err_q;
		right_d = right_q;
		cmd     = '0;
		fail    = 1'b0;
		fcode   = rie_pkg::ERR_NONE;
		ok      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_tok = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.kind)
					rie_pkg::KIND_CONST, rie_pkg::KIND_VAR: begin
						if (stat.full) begin
							fail  = 1'b1;
							fcode = rie_pkg::ERR_STACK_FULL;
						end else begin
							cmd.push = 1'b1;
							ok       = 1'b1;
						end
					end
					rie_pkg::KIND_END: begin
						fail  = 1'b1;
						fcode = rie_pkg::ERR_NO_RETURN;
					end
					default: begin
						if (stat.op > rie_pkg::OP_RETURN) begin
							fail  = 1'b1;
							fcode = rie_pkg::ERR_UNKNOWN_OP;
						end else if ((stat.op == rie_pkg::OP_RETURN) ? stat.depth_zero :
							stat.depth_lt2) begin
							fail  = 1'b1;
							fcode = rie_pkg::ERR_FEW_OPNDS;
						end else begin
							cmd.sread     = 1'b1;
							cmd.sread_top = (stat.op == rie_pkg::OP_RETURN);
							right_d       = 1'b0;
							state_d       = S_SCHK;
						end
					end
				endcase
			end
			S_SCHK: begin
				if (right_q && stat.op == rie_pkg::OP_ASSIGN) begin
					if (!stat.tag_var) begin
						fail  = 1'b1;
						fcode = rie_pkg::ERR_NOT_VAR;
					end else if (stat.idx_bad) begin
						fail  = 1'b1;
						fcode = rie_pkg::ERR_BAD_INDEX;
					end else if (stat.var_set) begin
						fail  = 1'b1;
						fcode = rie_pkg::ERR_REASSIGNED;
					end else begin
						cmd.var_write = 1'b1;
						ok            = 1'b1;
					end
				end else if (stat.tag_var) begin
					if (stat.idx_bad) begin
						fail  = 1'b1;
						fcode = rie_pkg::ERR_BAD_INDEX;
					end else if (!stat.var_set) begin
						fail  = 1'b1;
						fcode = rie_pkg::ERR_UNASSIGNED;
					end else begin
						cmd.vread = 1'b1;
						state_d   = S_VCHK;
					end
				end else begin
					cmd.load_opnd  = 1'b1;
					cmd.opnd_right = right_q;
					state_d        = S_NEXT;
				end
			end
			S_VCHK: begin
				cmd.load_opnd    = 1'b1;
				cmd.opnd_src_var = 1'b1;
				cmd.opnd_right   = right_q;
				state_d          = S_NEXT;
			end
			S_NEXT: begin
				if (!right_q) begin
					if (stat.op == rie_pkg::OP_RETURN) begin
						st_d    = rie_pkg::ST_RET;
						err_d   = rie_pkg::ERR_NONE;
						state_d = S_EMIT;
					end else begin
						cmd.sread     = 1'b1;
						cmd.sread_top = 1'b1;
						right_d       = 1'b1;
						state_d       = S_SCHK;
					end
				end else if (stat.op == rie_pkg::OP_DIV && stat.rv_zero) begin
					fail  = 1'b1;
					fcode = rie_pkg::ERR_DIV_ZERO;
				end else if (stat.op == rie_pkg::OP_MUL || stat.op == rie_pkg::OP_DIV) begin
					cmd.unit_start = 1'b1;
					state_d        = S_UNIT;
				end else begin
					state_d = S_WB;
				end
			end
			S_UNIT: begin
				if (stat.unit_done) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.stack_wb = 1'b1;
				ok           = 1'b1;
			end
			S_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = st_q;
					cmd.emit_err    = err_q;
					cmd.clear       = (st_q != rie_pkg::ST_OK);
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fail) begin
			st_d    = rie_pkg::ST_ERR;
			err_d   = fcode;
			state_d = S_EMIT;
		end else if (ok) begin
			st_d    = rie_pkg::ST_OK;
			err_d   = rie_pkg::ERR_NONE;
			state_d = S_EMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= rie_pkg::ST_OK;
			err_q   <= rie_pkg::ERR_NONE;
			right_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			err_q   <= err_d;
			right_q <= right_d;
		end
	end

endmodule

FILE: bench/rie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_checker
// watches the token and result channels of the rpn evaluator, keeps its own
// stack and variable file, predicts one result per accepted request and
// compares each delivered result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module rie_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        token_kind,
	input  logic [2:0]        operation,
	input  logic [63:0]       const_value,
	input  logic [6:0]        const_bits,
	input  logic [7:0]        var_index,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [3:0]        error_code,
	input  logic [63:0]       result_value,
	input  logic [6:0]        result_bits,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [1:0]  st;
		logic [3:0]  err;
		logic [63:0] val;
		logic [6:0]  bits;
	} outcome_t;

	outcome_t    expected_q[$];
	logic [63:0] opnd_val[rie_pkg::StackDepth];
	logic        opnd_is_var[rie_pkg::StackDepth];
	logic [7:0]  opnd_tag[rie_pkg::StackDepth];
	int          depth;
	logic [63:0] var_val[rie_pkg::NumVars];
	logic [6:0]  var_bits[rie_pkg::NumVars];
	logic        var_set[rie_pkg::NumVars];

	assign pending = expected_q.size();

	function automatic logic [63:0] to_container(logic [63:0] v, int b);
		if (b <= 8) return {{56{v[7]}}, v[7:0]};
		if (b <= 16) return {{48{v[15]}}, v[15:0]};
		if (b <= 32) return {{32{v[31]}}, v[31:0]};
		return v;
	endfunction

	function automatic void wipe();
		depth = 0;
		for (int i = 0; i < rie_pkg::NumVars; i++) var_set[i] = 1'b0;
	endfunction

	function automatic logic [3:0] fetch(int slot, output logic [63:0] v, output int b);
		int idx;
		v = '0;
		b = 0;
		if (!opnd_is_var[slot]) begin
			v = opnd_val[slot];
			b = opnd_tag[slot];
			return rie_pkg::ERR_NONE;
		end
		idx = opnd_tag[slot];
		if (idx >= rie_pkg::NumVars) return rie_pkg::ERR_BAD_INDEX;
		if (!var_set[idx]) return rie_pkg::ERR_UNASSIGNED;
		v = var_val[idx];
		b = var_bits[idx];
		return rie_pkg::ERR_NONE;
	endfunction

	function automatic outcome_t evaluate(logic [1:0] k, logic [2:0] op,
		logic [63:0] cv, logic [6:0] cb, logic [7:0] vi);
		outcome_t    r;
		logic [3:0]  e;
		logic [63:0] lv, rv, res, ma, mb, lim, q;
		int          lb, rb, w, b, idx;
		logic        ovf;
		r = '0;
		ovf = 1'b0;
		if (k == rie_pkg::KIND_CONST || k == rie_pkg::KIND_VAR) begin
			if (depth >= rie_pkg::StackDepth) begin
				wipe(); r.st = rie_pkg::ST_ERR; r.err = rie_pkg::ERR_STACK_FULL; return r;
			end
			if (k == rie_pkg::KIND_CONST) begin
				b = (cb == 0) ? 1 : (cb > 64) ? 64 : int'(cb);
				opnd_val[depth] = to_container(cv, b);
				opnd_is_var[depth] = 1'b0;
				opnd_tag[depth] = 8'(b);
			end else begin
				opnd_val[depth] = '0;
				opnd_is_var[depth] = 1'b1;
				opnd_tag[depth] = vi;
			end
			depth++;
			return r;
		end
		r.st = rie_pkg::ST_ERR;
		if (k == rie_pkg::KIND_END) begin
			wipe(); r.err = rie_pkg::ERR_NO_RETURN; return r;
		end
		if (op > rie_pkg::OP_RETURN) begin
			wipe(); r.err = rie_pkg::ERR_UNKNOWN_OP; return r;
		end
		if (depth < ((op == rie_pkg::OP_RETURN) ? 1 : 2)) begin
			wipe(); r.err = rie_pkg::ERR_FEW_OPNDS; return r;
		end
		if (op == rie_pkg::OP_RETURN) begin
			e = fetch(depth - 1, lv, lb);
			wipe();
			if (e != rie_pkg::ERR_NONE) begin
				r.err = e; return r;
			end
			r.st = rie_pkg::ST_RET; r.val = lv; r.bits = 7'(lb);
			return r;
		end
		e = fetch(depth - 2, lv, lb);
		if (e != rie_pkg::ERR_NONE) begin
			wipe(); r.err = e; return r;
		end
		if (op == rie_pkg::OP_ASSIGN) begin
			idx = opnd_tag[depth - 1];
			if (!opnd_is_var[depth - 1]) e = rie_pkg::ERR_NOT_VAR;
			else if (idx >= rie_pkg::NumVars) e = rie_pkg::ERR_BAD_INDEX;
			else if (var_set[idx]) e = rie_pkg::ERR_REASSIGNED;
			if (e != rie_pkg::ERR_NONE) begin
				wipe(); r.err = e; return r;
			end
			var_val[idx] = lv; var_bits[idx] = 7'(lb); var_set[idx] = 1'b1;
			depth -= 2;
			r.st = rie_pkg::ST_OK;
			return r;
		end
		e = fetch(depth - 1, rv, rb);
		if (e != rie_pkg::ERR_NONE) begin
			wipe(); r.err = e; return r;
		end
		w = (lb > rb) ? lb : rb;
		ma = lv[63] ? -lv : lv;
		mb = rv[63] ? -rv : rv;
		case (op)
			rie_pkg::OP_ADD: begin
				res = lv + rv;
				ovf = (lv[63] ^ res[63]) & (rv[63] ^ res[63]);
			end
			rie_pkg::OP_SUB: begin
				res = lv - rv;
				ovf = (lv[63] ^ rv[63]) & (lv[63] ^ res[63]);
			end
			rie_pkg::OP_MUL: begin
				res = lv * rv;
				lim = (lv[63] ^ rv[63]) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
				if (ma != 0 && mb != 0) ovf = mb > lim / ma;
			end
			default: begin
				if (rv == 0) begin
					wipe(); r.err = rie_pkg::ERR_DIV_ZERO; return r;
				end
				q = ma / mb;
				res = (lv[63] ^ rv[63]) ? -q : q;
			end
		endcase
		if (ovf) w = (w * 2 > 64) ? 64 : w * 2;
		depth--;
		opnd_val[depth - 1] = to_container(res, w);
		opnd_is_var[depth - 1] = 1'b0;
		opnd_tag[depth - 1] = 8'(w);
		r.st = rie_pkg::ST_OK;
		return r;
	endfunction

	initial begin
		fail_count = 0;
		wipe();
	end

	always @(posedge clk) begin
		outcome_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				x = expected_q.pop_front();
				if (status !== x.st) begin
					$error("status exp %0d got %0d", x.st, status); fail_count++;
				end
				if (error_code !== x.err) begin
					$error("error_code exp %0d got %0d", x.err, error_code); fail_count++;
				end
				if (result_value !== x.val) begin
					$error("result_value exp %h got %h", x.val, result_value); fail_count++;
				end
				if (result_bits !== x.bits) begin
					$error("result_bits exp %0d got %0d", x.bits, result_bits); fail_count++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall)
			expected_q.push_back(evaluate(token_kind, operation, const_value,
				const_bits, var_index));
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the rpn evaluator: directed corner programs, then random
// mostly well-formed programs mixed with noise, with random gaps on both channels
// ----------------------------------------------------------------------------
module tb;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [1:0]  token_kind, status;
	logic [2:0]  operation;
	logic [63:0] const_value, result_value;
	logic [6:0]  const_bits, result_bits;
	logic [7:0]  var_index;
	logic [3:0]  error_code;
	int          fail_count, pending;

	rpn_integer_evaluator DUT (.*);

	rie_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("FAIL");
		$finish;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(0, 99) < 25);
			if ($urandom_range(0, 99) < 3) begin
				out_stall = 1'b1;
				repeat ($urandom_range(10, 150)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic send(logic [1:0] k, logic [2:0] op, logic [63:0] v,
		logic [6:0] b, logic [7:0] idx);
		int g;
		g = gap_len();
		repeat (g) @(negedge clk);
		token_kind = k; operation = op; const_value = v; const_bits = b;
		var_index = idx; in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic push_num(logic [63:0] v, logic [6:0] b);
		send(rie_pkg::KIND_CONST, rie_pkg::OP_ADD, v, b, 8'($urandom));
	endtask

	task automatic push_ref(logic [7:0] idx);
		send(rie_pkg::KIND_VAR, 3'($urandom), {$urandom, $urandom}, 7'($urandom), idx);
	endtask

	task automatic do_op(logic [2:0] op);
		send(rie_pkg::KIND_OP, op, {$urandom, $urandom}, 7'($urandom), 8'($urandom));
	endtask

	function automatic logic [63:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'($urandom_range(0, 3)) - 64'd1;
			3: return {{32{1'b0}}, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [6:0] rand_bits();
		case ($urandom_range(0, 4))
			0: return 7'($urandom_range(0, 8));
			1: return 7'($urandom);
			2: return 7'd64;
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	// one random program: operands, a few arithmetic ops, assigns, then mostly a return
	task automatic random_program();
		int n, d, assigned;
		logic [2:0] op;
		d = 0;
		assigned = 0;
		n = $urandom_range(2, 8);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 2 && assigned != 0)
				push_ref(8'($urandom_range(0, 3)));
			else
				push_num(rand_val(), rand_bits());
			d++;
			if (d >= 2 && $urandom_range(0, 2) != 0) begin
				if ($urandom_range(0, 5) == 0) begin
					push_ref(8'($urandom_range(0, 3)));
					do_op(rie_pkg::OP_ASSIGN);
					assigned++;
					d--;
				end else begin
					if ($urandom_range(0, 9) < 3)
						op = ($urandom_range(0, 1) != 0) ? rie_pkg::OP_DIV : rie_pkg::OP_MUL;
					else
						op = ($urandom_range(0, 1) != 0) ? rie_pkg::OP_SUB : rie_pkg::OP_ADD;
					do_op(op);
					d--;
				end
			end
		end
		case ($urandom_range(0, 19))
			0: send(rie_pkg::KIND_END, 3'($urandom), '0, '0, '0);
			1: do_op(3'($urandom_range(6, 7)));
			2: push_ref(8'($urandom));
			default: do_op(rie_pkg::OP_RETURN);
		endcase
	endtask

	initial begin
		in_valid = 1'b0;
		token_kind = rie_pkg::KIND_CONST; operation = rie_pkg::OP_ADD;
		const_value = '0; const_bits = '0; var_index = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// extremes and overflow growth
		push_num(64'h7fff_ffff_ffff_ffff, 7'd64);
		push_num(64'd1, 7'd0);
		do_op(rie_pkg::OP_ADD);
		do_op(rie_pkg::OP_RETURN);
		push_num(64'h8000_0000_0000_0000, 7'd127);
		push_num(-64'sd1, 7'd64);
		do_op(rie_pkg::OP_DIV);
		do_op(rie_pkg::OP_RETURN);
		push_num(64'h1_0000_00ff, 7'd9);
		push_num(64'hffff_ffff_ffff_ff81, 7'd33);
		do_op(rie_pkg::OP_MUL);
		do_op(rie_pkg::OP_SUB);
		// divide by zero, few operands, unknown ops, end
		push_num(64'd5, 7'd8);
		push_num(64'd0, 7'd8);
		do_op(rie_pkg::OP_DIV);
		do_op(rie_pkg::OP_ADD);
		do_op(3'd6);
		do_op(3'd7);
		send(rie_pkg::KIND_END, '0, '0, '0, '0);
		// variables: assign, reassign, not-var target, bad index, unassigned
		push_num(64'd42, 7'd16);
		push_ref(8'd15);
		do_op(rie_pkg::OP_ASSIGN);
		push_ref(8'd15);
		push_num(64'd1, 7'd1);
		push_ref(8'd15);
		do_op(rie_pkg::OP_ASSIGN);
		push_num(64'd1, 7'd1); push_num(64'd2, 7'd2); do_op(rie_pkg::OP_ASSIGN);
		push_num(64'd1, 7'd1); push_ref(8'd255); do_op(rie_pkg::OP_ASSIGN);
		push_ref(8'd200); do_op(rie_pkg::OP_RETURN);
		push_ref(8'd3); do_op(rie_pkg::OP_RETURN);
		// stack full
		for (int i = 0; i <= rie_pkg::StackDepth; i++) push_num(64'($urandom), rand_bits());

		for (int t = 0; t < 150; t++) begin
			if ($urandom_range(0, 9) == 0)
				send(2'($urandom), 3'($urandom), {$urandom, $urandom}, 7'($urandom),
					8'($urandom));
			else
				random_program();
		end

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/rie_pkg.sv
design/rie_muldiv.sv
design/rie_dpath.sv
design/rie_ctrl.sv
design/rpn_integer_evaluator.sv
bench/rie_checker.sv
bench/tb.sv
